// File: hdl/qdv_pkg.sv
// Shared types and constants for the quadrature decoder with velocity capture.
package qdv_pkg;

    typedef enum logic [1:0] {
        CMD_PIN   = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_INDEX = 2'd2,
        CMD_LOAD  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STEP_NONE    = 2'd0,
        STEP_UP      = 2'd1,
        STEP_DOWN    = 2'd2,
        STEP_ILLEGAL = 2'd3
    } step_t;

    localparam int unsigned POS_W      = 32;
    localparam int unsigned PHASE_W    = 2;
    localparam int unsigned INTERVAL_W = 4;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 128;
    localparam int unsigned OUT_USER_W = 1;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 4'd2;

    // Indexed by [new phase][previous phase], phase = {B, A}
    localparam step_t STEP_TABLE [4][4] = '{
        '{STEP_NONE,    STEP_DOWN,    STEP_UP,      STEP_ILLEGAL},
        '{STEP_UP,      STEP_NONE,    STEP_ILLEGAL, STEP_DOWN},
        '{STEP_DOWN,    STEP_ILLEGAL, STEP_NONE,    STEP_UP},
        '{STEP_ILLEGAL, STEP_UP,      STEP_DOWN,    STEP_NONE}
    };

endpackage

// File: hdl/quadrature_decoder_velocity.sv
// An input transfer is held in the input register; its result is registered in the state registers on the master side.
// Throughput: one item per cycle while m_axis_tready keeps the result slot draining; the input register
// and the state update set that figure, with the state registers doubling as the result register.
// Reset: asynchronous, active low; clears position, velocity, acceleration,
// revolution and tick state, and sets the acceleration interval to 2.
module quadrature_decoder_velocity
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [qdv_pkg::INTERVAL_W-1:0]     cfg_wr_data,  // accel_interval
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [qdv_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // pin_a, pin_b, load_value, pad
    input  logic [qdv_pkg::IN_USER_W-1:0]      s_axis_tuser,  // command
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [qdv_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // position_count, velocity_count,
                                                              // accel_count, rev_counts
    output logic [qdv_pkg::OUT_USER_W-1:0]     m_axis_tuser   // illegal_step
);

    localparam int unsigned PW = qdv_pkg::POS_W;

    logic [qdv_pkg::INTERVAL_W-1:0]    accel_interval_reg;

    // Input register
    logic                              s1_valid_reg;
    qdv_pkg::cmd_t                     s1_cmd_reg;
    logic [qdv_pkg::PHASE_W-1:0]       s1_phase_reg;
    logic signed [PW-1:0]              s1_load_reg;
    logic                              s1_advance;

    // Decoder state, which also forms the result payload
    logic [qdv_pkg::PHASE_W-1:0]       prev_phase_reg,    prev_phase_next;
    logic signed [PW-1:0]              position_reg,      position_next;
    logic signed [PW-1:0]              tick_position_reg, tick_position_next;
    logic signed [PW-1:0]              velocity_reg,      velocity_next;
    logic signed [PW-1:0]              prev_velocity_reg, prev_velocity_next;
    logic signed [PW-1:0]              accel_reg,         accel_next;
    logic signed [PW-1:0]              rev_start_reg,     rev_start_next;
    logic signed [PW-1:0]              rev_reg,           rev_next;
    logic [qdv_pkg::INTERVAL_W-1:0]    tick_counter_reg,  tick_counter_next;
    logic                              illegal_reg,       illegal_next;
    logic                              out_valid_reg;

    qdv_pkg::step_t                    step;
    logic [qdv_pkg::INTERVAL_W-1:0]    interval_eff;
    logic [qdv_pkg::INTERVAL_W-1:0]    tick_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_interval_reg <= qdv_pkg::INTERVAL_RESET;
        end
        else if (cfg_wr_en)
        begin
            accel_interval_reg <= cfg_wr_data;
        end
    end

    // Advance when the result slot is empty or being drained
    assign s1_advance    = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            s1_cmd_reg   <= qdv_pkg::cmd_t'(s_axis_tuser);
            s1_phase_reg <= {s_axis_tdata[1], s_axis_tdata[0]};
            s1_load_reg  <= s_axis_tdata[33:2];
        end
    end

    assign step         = qdv_pkg::STEP_TABLE[s1_phase_reg][prev_phase_reg];
    assign interval_eff = (accel_interval_reg == '0) ? 4'd1 : accel_interval_reg;
    assign tick_inc     = tick_counter_reg + 4'd1;

    always_comb
    begin
        prev_phase_next    = prev_phase_reg;
        position_next      = position_reg;
        tick_position_next = tick_position_reg;
        velocity_next      = velocity_reg;
        prev_velocity_next = prev_velocity_reg;
        accel_next         = accel_reg;
        rev_start_next     = rev_start_reg;
        rev_next           = rev_reg;
        tick_counter_next  = tick_counter_reg;
        illegal_next       = 1'b0;
        case (s1_cmd_reg)
            qdv_pkg::CMD_PIN:
            begin
                prev_phase_next = s1_phase_reg;
                case (step)
                    qdv_pkg::STEP_UP:      position_next = position_reg + 32'sd1;
                    qdv_pkg::STEP_DOWN:    position_next = position_reg - 32'sd1;
                    qdv_pkg::STEP_ILLEGAL: illegal_next  = 1'b1;
                    default:               position_next = position_reg;
                endcase
            end
            qdv_pkg::CMD_TICK:
            begin
                velocity_next      = position_reg - tick_position_reg;
                tick_position_next = position_reg;
                tick_counter_next  = tick_inc;
                // Latch acceleration when the count reaches or passes the interval, or wraps to zero
                if (tick_inc >= interval_eff || tick_inc == '0)
                begin
                    accel_next         = position_reg - tick_position_reg - prev_velocity_reg;
                    prev_velocity_next = position_reg - tick_position_reg;
                    tick_counter_next  = '0;
                end
            end
            qdv_pkg::CMD_INDEX:
            begin
                rev_next       = position_reg - rev_start_reg;
                rev_start_next = position_reg;
            end
            qdv_pkg::CMD_LOAD:
            begin
                position_next = s1_load_reg;
            end
            default:
            begin
                position_next = position_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_phase_reg    <= '0;
            position_reg      <= '0;
            tick_position_reg <= '0;
            velocity_reg      <= '0;
            prev_velocity_reg <= '0;
            accel_reg         <= '0;
            rev_start_reg     <= '0;
            rev_reg           <= '0;
            tick_counter_reg  <= '0;
            illegal_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                prev_phase_reg    <= prev_phase_next;
                position_reg      <= position_next;
                tick_position_reg <= tick_position_next;
                velocity_reg      <= velocity_next;
                prev_velocity_reg <= prev_velocity_next;
                accel_reg         <= accel_next;
                rev_start_reg     <= rev_start_next;
                rev_reg           <= rev_next;
                tick_counter_reg  <= tick_counter_next;
                illegal_reg       <= illegal_next;
                out_valid_reg     <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // State only moves when a new result is loaded, so it holds under stall
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {rev_reg, accel_reg, velocity_reg, position_reg};
    assign m_axis_tuser  = illegal_reg;

    a_illegal_only_on_pin: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_cmd_reg != qdv_pkg::CMD_PIN) |=> !m_axis_tuser[0])
        else $error("illegal step flagged on a non-pin command");

    a_position_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && (s1_cmd_reg == qdv_pkg::CMD_TICK || s1_cmd_reg == qdv_pkg::CMD_INDEX))
        |=> $stable(position_reg))
        else $error("position moved on a tick or index command");

    a_illegal_holds_position: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && illegal_next) |=> $stable(position_reg))
        else $error("position moved on an illegal transition");

    a_tick_counter_range: assert property (@(posedge clk) disable iff (!rst_n)
        tick_counter_reg != 4'hF)
        else $error("tick counter passed the largest interval");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with the result slot empty");

endmodule
